// ----- src/swpr_pkg.sv -----
package swpr_pkg;

  localparam int unsigned Depth  = 32;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountOutW = 6;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_POP_EVEN = 2'd2,
    CMD_POP_ODD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TOP_RD,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [WordW-1:0]  push_value;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WordW-1:0]  top_value;
    logic                     is_empty;
    logic [CountOutW-1:0]     entry_count;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [WordW-1:0]  wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- src/swpr_store.sv -----
module swpr_store (
  input  logic                           clk_i,
  input  swpr_pkg::mem_req_t             mem_req_i,
  output logic [swpr_pkg::WordW-1:0]     rd_data_o
);

  logic [swpr_pkg::WordW-1:0] mem [swpr_pkg::Depth];
  logic [swpr_pkg::WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rd_data_q <= mem[mem_req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/swpr_seq.sv -----
module swpr_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  swpr_pkg::in_t                  in_data_i,
  output logic                           res_valid_o,
  input  logic                           res_free_i,
  output swpr_pkg::out_t                 res_o,
  output swpr_pkg::mem_req_t             mem_req_o,
  input  logic [swpr_pkg::WordW-1:0]     rd_data_i
);

  localparam int unsigned AW = swpr_pkg::AddrW;
  localparam int unsigned CW = swpr_pkg::CountW;

  swpr_pkg::state_e  state_q, state_d;
  swpr_pkg::status_e status_q, status_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              want_odd_q, want_odd_d;

  logic              is_full, is_zero, shift_more;
  logic [CW-1:0]     idx_inc;

  assign is_full    = (cnt_q == CW'(swpr_pkg::Depth));
  assign is_zero    = (cnt_q == '0);
  assign idx_inc    = idx_q + CW'(1);
  assign shift_more = (idx_inc < cnt_q);

  // next state and datapath registers
  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    want_odd_d = want_odd_q;
    unique case (state_q)
      swpr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          status_d = swpr_pkg::ST_OK;
          state_d  = swpr_pkg::S_TOP_RD;
          unique case (in_data_i.cmd)
            swpr_pkg::CMD_PUSH: begin
              if (is_full) begin
                status_d = swpr_pkg::ST_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            swpr_pkg::CMD_POP: begin
              if (is_zero) begin
                status_d = swpr_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            swpr_pkg::CMD_POP_EVEN, swpr_pkg::CMD_POP_ODD: begin
              if (is_zero) begin
                status_d = swpr_pkg::ST_EMPTY;
              end else begin
                idx_d      = cnt_q;
                want_odd_d = in_data_i.cmd[0];
                state_d    = swpr_pkg::S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      swpr_pkg::S_SCAN_RD: begin
        if (idx_q == '0) begin
          status_d = swpr_pkg::ST_NOMATCH;
          state_d  = swpr_pkg::S_TOP_RD;
        end else begin
          idx_d   = idx_q - CW'(1);
          state_d = swpr_pkg::S_SCAN_CHK;
        end
      end
      swpr_pkg::S_SCAN_CHK: begin
        if (rd_data_i[0] == want_odd_q) begin
          state_d = swpr_pkg::S_SHIFT_RD;
        end else begin
          state_d = swpr_pkg::S_SCAN_RD;
        end
      end
      swpr_pkg::S_SHIFT_RD: begin
        if (shift_more) begin
          state_d = swpr_pkg::S_SHIFT_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = swpr_pkg::S_TOP_RD;
        end
      end
      swpr_pkg::S_SHIFT_WR: begin
        idx_d   = idx_inc;
        state_d = swpr_pkg::S_SHIFT_RD;
      end
      swpr_pkg::S_TOP_RD: begin
        state_d = swpr_pkg::S_DONE;
      end
      swpr_pkg::S_DONE: begin
        if (res_free_i) begin
          state_d = swpr_pkg::S_IDLE;
        end
      end
      default: state_d = swpr_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_req_o       = '0;
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    unique case (state_q)
      swpr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_data_i.cmd == swpr_pkg::CMD_PUSH && !is_full) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = AW'(cnt_q);
          mem_req_o.wdata = in_data_i.push_value;
        end
      end
      swpr_pkg::S_SCAN_RD: begin
        mem_req_o.re    = (idx_q != '0);
        mem_req_o.raddr = AW'(idx_q - CW'(1));
      end
      swpr_pkg::S_SHIFT_RD: begin
        mem_req_o.re    = shift_more;
        mem_req_o.raddr = AW'(idx_inc);
      end
      swpr_pkg::S_SHIFT_WR: begin
        // entry above the gap moves down one place
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(idx_q);
        mem_req_o.wdata = rd_data_i;
      end
      swpr_pkg::S_TOP_RD: begin
        mem_req_o.re    = !is_zero;
        mem_req_o.raddr = AW'(cnt_q - CW'(1));
      end
      swpr_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.status      = status_q;
    res_o.top_value   = is_zero ? '0 : rd_data_i;
    res_o.is_empty    = is_zero;
    res_o.entry_count = swpr_pkg::CountOutW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= swpr_pkg::S_IDLE;
      status_q   <= swpr_pkg::ST_OK;
      cnt_q      <= '0;
      idx_q      <= '0;
      want_odd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      status_q   <= status_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      want_odd_q <= want_odd_d;
    end
  end

endmodule

// ----- src/stack_with_parity_removal_unit.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (swpr_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_data_o (swpr_pkg::out_t)
//
// push and pop pass the sequencer through idle (accept), top read and done, and the
// result shows once the done word is in the output register; a parity pop scans down
// for the wanted parity, shifts the entries above a match down and reads the top, using
// the single storage port with its registered read, one access per sequencer step.
// reset empties the stack at once; storage contents are not cleared.
// a finished word waits in the output register while the next word is taken;
// a stalled output holds the sequencer in its final state until the slot frees.
module stack_with_parity_removal_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  swpr_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output swpr_pkg::out_t  out_data_o
);

  swpr_pkg::mem_req_t          mem_req;
  logic [swpr_pkg::WordW-1:0]  rd_data;
  logic                        res_valid, res_free;
  swpr_pkg::out_t              res;
  logic                        out_valid_q;
  swpr_pkg::out_t              out_data_q;

  assign res_free = !out_valid_q || out_ready_i;

  swpr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_free_i  (res_free),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  swpr_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
